### hdl/olist_pkg.sv
// Ordered list engine: shared constants, codes and the structs passed between
// the controller and the row of storage cells. No dependencies.
package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_SEARCH = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // list update, applied by every cell in the same cycle
  typedef struct packed {
    logic             en;
    logic             del;
    logic [IDX_W-1:0] pos;
    entry_t           ent;
  } wr_t;

  // lookup qualifiers, held steady while a probe runs down the row
  typedef struct packed {
    logic             rd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } scan_t;

  // probe word handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } carry_t;

endpackage

### hdl/ordered_list_insert_delete_search.sv
// Ordered list engine top level: controller plus a row of storage cells.
// Depends on olist_pkg, olist_ctrl and olist_cell.
//
// Usage:
//  - A command word (in_command, in_position, in_key_in, in_payload_in) is
//    taken at a clock edge with start high and busy low.
//  - Each command gives exactly one result word, shown for one cycle with
//    out_valid high; the receiver cannot hold it off and need not.
//  - Append, remove last, insert and delete: the cells at and past the
//    position shift in the accept cycle, the result follows in the next cycle,
//    and a new command may be given in the very next cycle (one command per cycle).
//  - Search and read: a probe word walks the row of cells, one cell a
//    cycle, picking up the first hit. busy is high until the result is
//    given; the row length sets how long the walk takes.
//  - Failed commands (full, empty, bad index) report at once and leave the
//    list untouched; reads past the count report a bad index without a walk.
//  - out_count_out and out_empty_flag give the count after the command.
//  - Reset (synchronous, rst_n low) empties the list and drops any probe in
//    flight; stored entries are left as they are and are unreachable.
module ordered_list_insert_delete_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_position,
  input  logic [31:0] in_key_in,
  input  logic [31:0] in_payload_in,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_found_position,
  output logic [31:0] out_key_out,
  output logic [31:0] out_payload_out,
  output logic [6:0]  out_count_out,
  output logic        out_empty_flag
);
  import olist_pkg::*;

  wr_t    wr;
  scan_t  scan;
  entry_t ents   [CAPACITY];
  carry_t carries[CAPACITY+1];

  olist_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_key_in          (in_key_in),
    .in_payload_in      (in_payload_in),
    .wr                 (wr),
    .scan               (scan),
    .launch             (carries[0]),
    .carry_last         (carries[CAPACITY]),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_payload_out    (out_payload_out),
    .out_count_out      (out_count_out),
    .out_empty_flag     (out_empty_flag)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_ent, right_ent;

    if (g == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ents[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ents[g+1];
    end

    olist_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .wr        (wr),
      .scan      (scan),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ents[g]),
      .carry_in  (carries[g]),
      .carry_out (carries[g+1])
    );
  end

endmodule

### hdl/olist_cell.sv
// Ordered list engine: one storage cell, holding a single entry, shifting with
// its neighbours and passing the lookup probe on. Depends on olist_pkg.
module olist_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [olist_pkg::IDX_W-1:0] cell_idx,
  input  olist_pkg::wr_t              wr,
  input  olist_pkg::scan_t            scan,
  input  olist_pkg::entry_t           left_ent,
  input  olist_pkg::entry_t           right_ent,
  output olist_pkg::entry_t           ent,
  input  olist_pkg::carry_t           carry_in,
  output olist_pkg::carry_t           carry_out
);
  import olist_pkg::*;

  entry_t ent_r;
  carry_t carry_r, carry_nxt;
  logic   hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (!wr.del) begin
        if (cell_idx == wr.pos) begin
          ent_r <= wr.ent;
        end else if (cell_idx > wr.pos) begin
          ent_r <= left_ent;
        end
      end else if (cell_idx >= wr.pos) begin
        ent_r <= right_ent;
      end
    end
  end

  always_comb begin
    hit = scan.rd ? (cell_idx == scan.pos)
                  : ((CNT_W'(cell_idx) < scan.count) && (ent_r.key == scan.key));
    carry_nxt = carry_in;
    if (carry_in.valid && !carry_in.found && hit) begin
      carry_nxt.found = 1'b1;
      carry_nxt.idx   = cell_idx;
      carry_nxt.ent   = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.valid <= 1'b0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign ent       = ent_r;
  assign carry_out = carry_r;

endmodule

### hdl/olist_ctrl.sv
// Ordered list engine: command decode, entry count, probe launch and result
// register. Depends on olist_pkg.
module olist_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_command,
  input  logic [5:0]                  in_position,
  input  logic [31:0]                 in_key_in,
  input  logic [31:0]                 in_payload_in,
  output olist_pkg::wr_t              wr,
  output olist_pkg::scan_t            scan,
  output olist_pkg::carry_t           launch,
  input  olist_pkg::carry_t           carry_last,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [5:0]                  out_found_position,
  output logic [31:0]                 out_key_out,
  output logic [31:0]                 out_payload_out,
  output logic [6:0]                  out_count_out,
  output logic                        out_empty_flag
);
  import olist_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  carry_t           launch_r;
  logic             rd_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] pos_r;
  logic             out_valid_r;
  status_t          out_status_r, st_c;
  logic [5:0]       out_fpos_r;
  logic [31:0]      out_key_r, out_pay_r;
  logic             acc, go_scan, go_rd;
  logic [CMP_W-1:0] pos_c, cnt_c;
  logic             full;
  entry_t           in_ent;

  assign acc    = start && (state_r == S_IDLE);
  assign pos_c  = CMP_W'(in_position);
  assign cnt_c  = CMP_W'(count_r);
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign in_ent = '{key: KEY_W'(in_key_in), pay: PAY_W'(in_payload_in)};

  always_comb begin
    wr        = '0;
    wr.ent    = in_ent;
    st_c      = ST_OK;
    count_nxt = count_r;
    go_scan   = 1'b0;
    go_rd     = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_APPEND: begin
        if (full) begin
          st_c = ST_FULL;
        end else begin
          wr.en     = acc;
          wr.pos    = IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) begin
          st_c = ST_EMPTY;
        end else begin
          wr.en     = acc;
          wr.del    = 1'b1;
          wr.pos    = IDX_W'(count_r - CNT_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (full) begin
          st_c = ST_FULL;
        end else if (pos_c > cnt_c) begin
          st_c = ST_BADIDX;
        end else begin
          wr.en     = acc;
          wr.pos    = IDX_W'(in_position);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (count_r == '0) begin
          st_c = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          st_c = ST_BADIDX;
        end else begin
          wr.en     = acc;
          wr.del    = 1'b1;
          wr.pos    = IDX_W'(in_position);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        go_scan = 1'b1;
      end
      CMD_READ: begin
        if (pos_c >= cnt_c) begin
          st_c = ST_BADIDX;
        end else begin
          go_scan = 1'b1;
          go_rd   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r    <= 1'b0;
      launch_r.valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            count_r <= count_nxt;
            if (go_scan) begin
              state_r        <= S_SCAN;
              launch_r.valid <= 1'b1;
              launch_r.found <= 1'b0;
              launch_r.idx   <= '0;
              launch_r.ent   <= '0;
              rd_r           <= go_rd;
              key_r          <= in_ent.key;
              pos_r          <= IDX_W'(in_position);
            end else begin
              out_valid_r  <= 1'b1;
              out_status_r <= st_c;
              out_fpos_r   <= '0;
              out_key_r    <= '0;
              out_pay_r    <= '0;
            end
          end
        end
        S_SCAN: begin
          if (carry_last.valid) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (carry_last.found) begin
              out_status_r <= ST_OK;
              // a read reports only the entry, not its index
              out_fpos_r   <= rd_r ? '0 : 6'(carry_last.idx);
              out_key_r    <= 32'(carry_last.ent.key);
              out_pay_r    <= 32'(carry_last.ent.pay);
            end else begin
              out_status_r <= ST_NOTFOUND;
              out_fpos_r   <= '0;
              out_key_r    <= '0;
              out_pay_r    <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_r == S_SCAN);
  assign launch = launch_r;
  assign scan   = '{rd: rd_r, key: key_r, pos: pos_r, count: count_r};

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_fpos_r;
  assign out_key_out        = out_key_r;
  assign out_payload_out    = out_pay_r;
  assign out_count_out      = 7'(count_r);
  assign out_empty_flag     = (count_r == '0);

endmodule

### tb/sv/olist_checker.sv
`timescale 1ns / 100ps
// Ordered list engine checker: watches command and result words, keeps its own
// copy of the list and compares every result word field by field. Needs olist_pkg.
module olist_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_position,
  input  logic [31:0] in_key_in,
  input  logic [31:0] in_payload_in,
  input  logic        out_valid,
  input  logic [2:0]  out_status,
  input  logic [5:0]  out_found_position,
  input  logic [31:0] out_key_out,
  input  logic [31:0] out_payload_out,
  input  logic [6:0]  out_count_out,
  input  logic        out_empty_flag,
  output int          fail_count,
  output int          pending
);
  import olist_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] found_pos;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic [CNT_W-1:0] count;
    logic             empty;
  } list_result_t;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [PAY_W-1:0] pay_mem [CAPACITY];
  logic [CNT_W-1:0] n_entries;
  list_result_t     due_results [$];

  function automatic void drop_entry(logic [CNT_W-1:0] idx);
    for (int i = idx; i + 1 < n_entries; i++) begin
      key_mem[i] = key_mem[i + 1];
      pay_mem[i] = pay_mem[i + 1];
    end
    n_entries--;
    key_mem[IDX_W'(n_entries)] = '0;
    pay_mem[IDX_W'(n_entries)] = '0;
  endfunction

  function automatic list_result_t apply_list_command(logic [2:0] cmd, logic [IDX_W-1:0] pos,
      logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    list_result_t r;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (n_entries >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          key_mem[IDX_W'(n_entries)] = key;
          pay_mem[IDX_W'(n_entries)] = pay;
          n_entries++;
        end
      end
      CMD_REMOVE: begin
        if (n_entries == 0) r.status = ST_EMPTY;
        else drop_entry(n_entries - CNT_W'(1));
      end
      CMD_INSERT: begin
        if (n_entries >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > n_entries) begin
          r.status = ST_BADIDX;
        end else begin
          for (int i = n_entries; i > pos; i--) begin
            key_mem[i] = key_mem[i - 1];
            pay_mem[i] = pay_mem[i - 1];
          end
          key_mem[pos] = key;
          pay_mem[pos] = pay;
          n_entries++;
        end
      end
      CMD_DELETE: begin
        if (n_entries == 0) r.status = ST_EMPTY;
        else if (pos >= n_entries) r.status = ST_BADIDX;
        else drop_entry(CNT_W'(pos));
      end
      CMD_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < n_entries; i++) begin
          if (r.status == ST_NOTFOUND && key_mem[i] == key) begin
            r.status    = ST_OK;
            r.found_pos = IDX_W'(i);
            r.key       = key_mem[i];
            r.pay       = pay_mem[i];
          end
        end
      end
      CMD_READ: begin
        if (pos >= n_entries) begin
          r.status = ST_BADIDX;
        end else begin
          r.key = key_mem[pos];
          r.pay = pay_mem[pos];
        end
      end
      default: ;
    endcase
    r.count = n_entries;
    r.empty = (n_entries == 0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // new command queued before the result is taken off: the queue stays in order
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      n_entries = '0;
      due_results.delete();
    end else begin
      if (start === 1'b1 && busy === 1'b0)
        due_results.insert(due_results.size(),
                           apply_list_command(in_command, in_position, in_key_in,
                                              in_payload_in));
      if (out_valid !== 1'b0) begin
        if (due_results.size() == 0) begin
          $error("result word with no command outstanding");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("found_position", want.found_pos, out_found_position);
          check_field("key_out", want.key, out_key_out);
          check_field("payload_out", want.pay, out_payload_out);
          check_field("count_out", want.count, out_count_out);
          check_field("empty_flag", want.empty, out_empty_flag);
        end
      end
    end
    pending = due_results.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Ordered list engine testbench top: clock, reset, command words and verdict.
// Needs olist_pkg, ordered_list_insert_delete_search and olist_checker.
module tb_top;
  import olist_pkg::*;

  localparam logic [2:0] CMD_NOP_LO  = 3'd6;
  localparam logic [2:0] CMD_NOP_HI  = 3'd7;
  localparam int         RAND_WORDS  = 850;
  localparam int         TAIL_CYCLES = CAPACITY + 4;
  localparam int         FULL_HOLD   = 8;
  localparam int         EMPTY_HOLD  = 4;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic [2:0]  in_command    = '0;
  logic [5:0]  in_position   = '0;
  logic [31:0] in_key_in     = '0;
  logic [31:0] in_payload_in = '0;
  logic        busy;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_found_position;
  logic [31:0] out_key_out;
  logic [31:0] out_payload_out;
  logic [6:0]  out_count_out;
  logic        out_empty_flag;
  int          fail_count;
  int          pending;
  logic [6:0]  seen_count = '0;
  int          burst_left = 0;

  always #2 clk = ~clk;

  ordered_list_insert_delete_search u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_key_in          (in_key_in),
    .in_payload_in      (in_payload_in),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_payload_out    (out_payload_out),
    .out_count_out      (out_count_out),
    .out_empty_flag     (out_empty_flag)
  );

  olist_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_position        (in_position),
    .in_key_in          (in_key_in),
    .in_payload_in      (in_payload_in),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_payload_out    (out_payload_out),
    .out_count_out      (out_count_out),
    .out_empty_flag     (out_empty_flag),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // rough fill level, only used to steer the random words
  always @(negedge clk) begin
    if (out_valid === 1'b1) seen_count <= out_count_out;
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // a small pool of keys gives search hits and duplicate keys
  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 1)) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h0000_ffff;
      5:       return 32'hffff_0000;
      6:       return 32'ha5a5_a5a5;
      default: return 32'h5a5a_5a5a;
    endcase
  endfunction

  function automatic logic [31:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h0000_0000;
    if (r < 10) return 32'hffff_ffff;
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_position();
    if ($urandom_range(0, 99) < 35) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, (seen_count > 63) ? 63 : seen_count));
  endfunction

  // start held over from the previous word unless a gap is taken
  task automatic send_word(input logic [2:0] cmd, input logic [5:0] pos,
                           input logic [31:0] key, input logic [31:0] pay);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_position   <= pos;
    in_key_in     <= key;
    in_payload_in <= pay;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random(input bit growing);
    int         r;
    logic [2:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 2) cmd = r[0] ? CMD_NOP_HI : CMD_NOP_LO;
    else if (r < (growing ? 37 : 7)) cmd = CMD_APPEND;
    else if (r < (growing ? 67 : 15)) cmd = CMD_INSERT;
    else if (r < (growing ? 72 : 45)) cmd = CMD_REMOVE;
    else if (r < 80) cmd = CMD_DELETE;
    else if (r < 90) cmd = CMD_SEARCH;
    else cmd = CMD_READ;
    send_word(cmd, pick_position(), pick_key(), pick_payload());
  endtask

  initial begin
    #3ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bit growing;
    int hold;
    growing = 1'b1;
    hold    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty list
    send_word(CMD_READ,   6'd0,  32'h0,         32'h0);
    send_word(CMD_SEARCH, 6'd0,  32'h0,         32'h0);
    send_word(CMD_REMOVE, 6'd0,  32'h0,         32'h0);
    send_word(CMD_DELETE, 6'd0,  32'h0,         32'h0);
    send_word(CMD_INSERT, 6'd1,  32'h1,         32'h1);
    // build up, insert at front, at count and past it
    send_word(CMD_APPEND, 6'd0,  32'h0,         32'h0);
    send_word(CMD_APPEND, 6'd63, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_INSERT, 6'd0,  32'h1234_5678, 32'h8765_4321);
    send_word(CMD_INSERT, 6'd3,  32'ha5a5_a5a5, 32'h5a5a_5a5a);
    send_word(CMD_INSERT, 6'd63, 32'h5555_5555, 32'haaaa_aaaa);
    send_word(CMD_READ,   6'd0,  32'h0,         32'h0);
    send_word(CMD_READ,   6'd3,  32'h0,         32'h0);
    send_word(CMD_READ,   6'd4,  32'h0,         32'h0);
    send_word(CMD_READ,   6'd63, 32'h0,         32'h0);
    send_word(CMD_SEARCH, 6'd0,  32'hffff_ffff, 32'h0);
    send_word(CMD_SEARCH, 6'd0,  32'h0,         32'h0);
    send_word(CMD_SEARCH, 6'd0,  32'h5555_5555, 32'h0);
    // removal at and past the end
    send_word(CMD_DELETE, 6'd4,  32'h0,         32'h0);
    send_word(CMD_DELETE, 6'd63, 32'h0,         32'h0);
    send_word(CMD_DELETE, 6'd1,  32'h0,         32'h0);
    send_word(CMD_REMOVE, 6'd0,  32'h0,         32'h0);
    send_word(CMD_NOP_LO, 6'd2,  32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_NOP_HI, 6'd0,  32'h0,         32'h0);

    // alternate filling to full and draining to empty
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (growing && seen_count == CAPACITY) hold++;
      if (!growing && seen_count == 0) hold++;
      if (hold > (growing ? FULL_HOLD : EMPTY_HOLD)) begin
        growing = !growing;
        hold    = 0;
      end
      send_random(growing);
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
